/* rtl/bops_pkg.sv */
package bops_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int TYPES_DEF = 8;

    localparam logic [2:0] MD_ADD   = 3'd0;
    localparam logic [2:0] MD_MARK  = 3'd1;
    localparam logic [2:0] MD_PURGE = 3'd2;
    localparam logic [2:0] MD_SCAN  = 3'd3;
    localparam logic [2:0] MD_CLEAR = 3'd4;

    localparam logic [2:0] ST_ADDED  = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_MARKED = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_PURGED = 3'd4;
    localparam logic [2:0] ST_NOTIFY = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic        [10:0] w;
        logic        [10:0] h;
        logic        [2:0]  btype;
        logic               listener;
    } t_box;

    localparam int BOX_BITS = $bits(t_box);

    typedef struct packed {
        logic fwd;
        logic rev;
    } t_pair_flags;

endpackage

/* rtl/bops_ram.sv */
module bops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bops_pair_eval.sv */
module bops_pair_eval
    import bops_pkg::*;
#(
    parameter int TYPES = TYPES_DEF
) (
    input  t_box        i_box_a,
    input  t_box        i_box_b,
    input  logic [63:0] i_matrix,
    output t_pair_flags o_flags
);

    logic signed [13:0] w_ax, w_ay, w_aw, w_ah;
    logic signed [13:0] w_bx, w_by, w_bw, w_bh;
    logic               w_hit;
    logic               w_ta_ok, w_tb_ok;

    always_comb begin
        w_ax = $signed({{2{i_box_a.x[11]}}, i_box_a.x});
        w_ay = $signed({{2{i_box_a.y[11]}}, i_box_a.y});
        w_aw = $signed({3'b000, i_box_a.w});
        w_ah = $signed({3'b000, i_box_a.h});
        w_bx = $signed({{2{i_box_b.x[11]}}, i_box_b.x});
        w_by = $signed({{2{i_box_b.y[11]}}, i_box_b.y});
        w_bw = $signed({3'b000, i_box_b.w});
        w_bh = $signed({3'b000, i_box_b.h});
        w_hit = (w_ax < w_bx + w_bw) && (w_ax + w_aw > w_bx) &&
                (w_ay < w_by + w_bh) && (w_ay + w_ah > w_by);
        w_ta_ok = 32'(i_box_a.btype) < 32'(TYPES);
        w_tb_ok = 32'(i_box_b.btype) < 32'(TYPES);
        o_flags.fwd = w_hit && i_box_a.listener && w_ta_ok && w_tb_ok &&
                      i_matrix[{i_box_a.btype, i_box_b.btype}];
        o_flags.rev = w_hit && i_box_b.listener && w_ta_ok && w_tb_ok &&
                      i_matrix[{i_box_b.btype, i_box_a.btype}];
    end

endmodule

/* rtl/box_overlap_pair_scanner.sv */
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_mode i_slot i_rect_* i_box_type i_has_listener
// result    out        o_valid / i_ready   o_status o_first_slot o_second_slot o_last
// config    in         i_cfg_we            i_cfg_data (notify matrix)
//
// Add, mark, purge and clear each give one result.
// A scan of row i reads each later stored box, one per cycle through the box memory
// read port while no notify waits, then gives a notify per hit and a done result.
// A stalled result holds the sequencer; the request side takes a new request once idle.
// Reset (synchronous, active low) empties the table and clears the matrix.
module box_overlap_pair_scanner
    import bops_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int TYPES = TYPES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic [4:0]         i_slot,
    input  logic signed [11:0] i_rect_x,
    input  logic signed [11:0] i_rect_y,
    input  logic [10:0]        i_rect_w,
    input  logic [10:0]        i_rect_h,
    input  logic [2:0]         i_box_type,
    input  logic               i_has_listener,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [4:0]         o_first_slot,
    output logic [4:0]         o_second_slot,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_data
);

    localparam int W = $clog2(SLOTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_LAT_I = 6'b000100,
        S_CMP   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [SLOTS-1:0]  r_used, n_used;
    logic [SLOTS-1:0]  r_erase, n_erase;
    logic [63:0]       r_matrix;
    logic [2:0]        r_mode;
    logic [4:0]        r_slot;
    t_box              r_new;
    t_box              r_bi, n_bi;
    logic [W-1:0]      r_row, n_row;
    logic [W-1:0]      r_k, n_k;
    logic              r_na, n_na;
    logic              r_nb, n_nb;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_status, n_status;
    logic [4:0]        r_first, n_first;
    logic [4:0]        r_second, n_second;
    logic              r_last, n_last;

    logic              w_accept;
    logic              w_out_free;
    logic              w_in_slot_ok;
    logic              w_req_slot_ok;
    logic              w_free_found;
    logic [W-1:0]      w_free_idx;
    logic              w_we;
    logic              w_re;
    logic [W-1:0]      w_raddr;
    logic [BOX_BITS-1:0] w_rdata;
    t_box              w_bk;
    t_pair_flags       w_flags;
    logic              w_k_last;

    assign w_accept      = i_valid && o_ready;
    assign w_out_free    = !r_out_valid || i_ready;
    assign w_in_slot_ok  = 32'(i_slot) < 32'(SLOTS);
    assign w_req_slot_ok = 32'(r_slot) < 32'(SLOTS);
    assign w_bk          = t_box'(w_rdata);
    assign w_k_last      = (r_k == W'(SLOTS - 1));

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_used[j]) begin
                w_free_found = 1'b1;
                w_free_idx   = W'(j);
            end
        end
    end

    bops_ram #(
        .WIDTH (BOX_BITS),
        .DEPTH (SLOTS)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_free_idx),
        .i_wdata (r_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bops_pair_eval #(
        .TYPES (TYPES)
    ) u_pair_eval (
        .i_box_a  (r_bi),
        .i_box_b  (w_bk),
        .i_matrix (r_matrix),
        .o_flags  (w_flags)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_erase     = r_erase;
        n_bi        = r_bi;
        n_row       = r_row;
        n_k         = r_k;
        n_na        = r_na;
        n_nb        = r_nb;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_first     = r_first;
        n_second    = r_second;
        n_last      = r_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_k + W'(1);
        o_ready     = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MD_ADD, MD_MARK, MD_PURGE, MD_CLEAR: begin
                            n_state = S_EXEC;
                        end
                        MD_SCAN: begin
                            if (w_in_slot_ok && r_used[i_slot[W-1:0]]) begin
                                w_re    = 1'b1;
                                w_raddr = i_slot[W-1:0];
                                n_row   = i_slot[W-1:0];
                                n_k     = i_slot[W-1:0];
                                n_state = S_LAT_I;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_first     = '0;
                    n_second    = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    case (r_mode)
                        MD_ADD: begin
                            if (w_free_found) begin
                                w_we                = 1'b1;
                                n_used[w_free_idx]  = 1'b1;
                                n_erase[w_free_idx] = 1'b0;
                                n_status            = ST_ADDED;
                                n_first             = 5'(w_free_idx);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        MD_MARK: begin
                            n_first = r_slot;
                            if (w_req_slot_ok && r_used[r_slot[W-1:0]]) begin
                                n_erase[r_slot[W-1:0]] = 1'b1;
                                n_status               = ST_MARKED;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        MD_PURGE: begin
                            n_used   = r_used & ~r_erase;
                            n_erase  = '0;
                            n_status = ST_PURGED;
                        end
                        default: begin
                            n_used   = '0;
                            n_erase  = '0;
                            n_status = ST_PURGED;
                        end
                    endcase
                end
            end
            S_LAT_I: begin
                n_bi = w_bk;
                if (w_k_last) begin
                    n_state = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_k     = r_k + W'(1);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_used[r_k] && (w_flags.fwd || w_flags.rev)) begin
                    n_na    = w_flags.fwd;
                    n_nb    = w_flags.rev;
                    n_state = S_EMIT;
                end else if (w_k_last) begin
                    n_state = S_DONE;
                end else begin
                    w_re = 1'b1;
                    n_k  = r_k + W'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NOTIFY;
                    n_last      = 1'b0;
                    if (r_na) begin
                        n_na     = 1'b0;
                        n_first  = 5'(r_row);
                        n_second = 5'(r_k);
                    end else begin
                        n_nb     = 1'b0;
                        n_first  = 5'(r_k);
                        n_second = 5'(r_row);
                    end
                    if (!(r_na && r_nb)) begin
                        if (w_k_last) begin
                            n_state = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            n_k     = r_k + W'(1);
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_first     = r_slot;
                    n_second    = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_erase     <= '0;
            r_matrix    <= '0;
            r_out_valid <= 1'b0;
            r_na        <= 1'b0;
            r_nb        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_erase     <= n_erase;
            r_out_valid <= n_out_valid;
            r_na        <= n_na;
            r_nb        <= n_nb;
            if (i_cfg_we) begin
                r_matrix <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode         <= i_mode;
            r_slot         <= i_slot;
            r_new.x        <= i_rect_x;
            r_new.y        <= i_rect_y;
            r_new.w        <= i_rect_w;
            r_new.h        <= i_rect_h;
            r_new.btype    <= i_box_type;
            r_new.listener <= i_has_listener;
        end
        r_bi     <= n_bi;
        r_row    <= n_row;
        r_k      <= n_k;
        r_status <= n_status;
        r_first  <= n_first;
        r_second <= n_second;
        r_last   <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_first_slot  = r_first;
    assign o_second_slot = r_second;
    assign o_last        = r_last;

    a_erase_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_erase & ~r_used) == '0)
        else $error("erase mark on an empty slot");

    a_k_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_EMIT) |-> (r_k > r_row))
        else $error("scan column not beyond row");

    a_notify_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOTIFY) |-> !o_last)
        else $error("notify marked as last");

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_na || r_nb))
        else $error("emit state with nothing pending");

endmodule
